/* rtl/text_console_char_engine_assert.svh */
// Assertion macros used by the console engine back module.
// Both expect a clock named aclk and an active-low reset named aresetn in scope.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define TCCE_ASSERT_IMP(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("tcce: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define TCCE_ASSERT_NXT(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("tcce: next-cycle check failed");

`endif

/* rtl/tcce_pkg.sv */
package tcce_pkg;

    // Default geometry of the screen.
    localparam int COLS_DEF     = 80;
    localparam int ROWS_DEF     = 25;
    localparam int TAB_STOP_DEF = 8;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes.
    localparam logic CFG_FG = 1'b0;
    localparam logic CFG_BG = 1'b1;

    // Operation codes of an input beat.
    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Byte codes with a special meaning.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] UTF_C2   = 8'hC2;
    localparam logic [7:0] UTF_C3   = 8'hC3;
    localparam logic [7:0] C2_LOW   = 8'hA1;
    localparam logic [7:0] C2_HIGH  = 8'hBF;

    // Cell written by the clearing pass: space, white on black.
    localparam logic [15:0] RESET_CELL = 16'h0F20;

    // Code page 437 codes for the second byte after 0xC2 (0xA1 to 0xBF).
    localparam logic [7:0] MAP_C2 [31] = '{
        8'd173, 8'd155, 8'd156, 8'd234, 8'd157, 8'd179, 8'd21,  8'd234,
        8'd234, 8'd166, 8'd234, 8'd170, 8'd174, 8'd234, 8'd234, 8'd248,
        8'd241, 8'd253, 8'd234, 8'd39,  8'd230, 8'd20,  8'd249, 8'd44,
        8'd49,  8'd167, 8'd175, 8'd172, 8'd171, 8'd234, 8'd168
    };

    // Code page 437 codes for the second byte after 0xC3 (0x80 to 0xBF).
    localparam logic [7:0] MAP_C3 [64] = '{
        8'd65,  8'd65,  8'd65,  8'd65,  8'd142, 8'd143, 8'd146, 8'd128,
        8'd69,  8'd144, 8'd69,  8'd69,  8'd73,  8'd73,  8'd73,  8'd73,
        8'd68,  8'd165, 8'd79,  8'd79,  8'd79,  8'd79,  8'd153, 8'd120,
        8'd79,  8'd85,  8'd85,  8'd85,  8'd154, 8'd89,  8'd48,  8'd225,
        8'd133, 8'd160, 8'd131, 8'd97,  8'd132, 8'd134, 8'd145, 8'd135,
        8'd138, 8'd130, 8'd136, 8'd137, 8'd141, 8'd161, 8'd140, 8'd139,
        8'd235, 8'd164, 8'd149, 8'd162, 8'd147, 8'd111, 8'd148, 8'd246,
        8'd237, 8'd151, 8'd163, 8'd150, 8'd129, 8'd121, 8'd0,   8'd152
    };

    // Kinds of work the back carries out.
    typedef enum logic [2:0] {
        CMD_NOP     = 3'd0,
        CMD_READ    = 3'd1,
        CMD_CHAR    = 3'd2,
        CMD_NEWLINE = 3'd3,
        CMD_TAB     = 3'd4,
        CMD_BACK    = 3'd5,
        CMD_DELETE  = 3'd6
    } cmd_kind_t;

    // One classified command in the queue.
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  chr;
        logic [10:0] idx;
    } cmd_t;

    // Input beat.
    typedef struct packed {
        logic        operation;
        logic [7:0]  byte_in;
        logic [10:0] cell_index;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic [10:0] cursor;
        logic [7:0]  cell_char;
        logic [3:0]  cell_fg;
        logic [3:0]  cell_bg;
    } out_item_t;

    // Status from the back to the front.
    typedef struct packed {
        logic clearing;
    } back_status_t;

    // Sort a character code into the work it causes.
    function automatic cmd_kind_t classify(input logic [7:0] c);
        cmd_kind_t k;
        unique case (c)
            CH_NUL:  k = CMD_NOP;
            CH_NL:   k = CMD_NEWLINE;
            CH_TAB:  k = CMD_TAB;
            CH_BS:   k = CMD_BACK;
            CH_DEL:  k = CMD_DELETE;
            default: k = CMD_CHAR;
        endcase
        return k;
    endfunction

endpackage

/* rtl/tcce_front.sv */
module tcce_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tcce_pkg::in_item_t    s_item,
    input  tcce_pkg::back_status_t status,
    input  logic                  q_ready,
    output logic                  q_valid,
    output tcce_pkg::cmd_t        q_cmd
);

    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_C2   = 2'd1,
        PFX_C3   = 2'd2
    } prefix_t;

    prefix_t    prefix_reg, prefix_next;
    logic       accept;
    logic [7:0] mapped;

    // Beats are taken while the queue has room and the screen is not being cleared.
    assign s_ready = q_ready && !status.clearing;
    assign accept  = s_valid && s_ready;
    assign q_valid = s_valid && !status.clearing;

    // Classify the beat and track a pending UTF-8 lead byte.
    always_comb begin
        prefix_next = prefix_reg;
        mapped      = tcce_pkg::CH_QMARK;
        q_cmd.idx   = s_item.cell_index;
        q_cmd.chr   = s_item.byte_in;
        q_cmd.kind  = tcce_pkg::CMD_NOP;
        if (s_item.operation == tcce_pkg::OP_READ) begin
            q_cmd.kind = tcce_pkg::CMD_READ;
        end else begin
            unique case (prefix_reg)
                PFX_C2: begin
                    if (s_item.byte_in >= tcce_pkg::C2_LOW &&
                        s_item.byte_in <= tcce_pkg::C2_HIGH) begin
                        mapped = tcce_pkg::MAP_C2[5'(s_item.byte_in - tcce_pkg::C2_LOW)];
                    end
                    prefix_next = PFX_NONE;
                    q_cmd.chr   = mapped;
                    q_cmd.kind  = tcce_pkg::classify(mapped);
                end
                PFX_C3: begin
                    if (s_item.byte_in[7:6] == 2'b10) begin
                        mapped = tcce_pkg::MAP_C3[s_item.byte_in[5:0]];
                    end
                    prefix_next = PFX_NONE;
                    q_cmd.chr   = mapped;
                    q_cmd.kind  = tcce_pkg::classify(mapped);
                end
                default: begin
                    if (s_item.byte_in == tcce_pkg::UTF_C2) begin
                        prefix_next = PFX_C2;
                    end else if (s_item.byte_in == tcce_pkg::UTF_C3) begin
                        prefix_next = PFX_C3;
                    end else begin
                        q_cmd.kind = tcce_pkg::classify(s_item.byte_in);
                    end
                end
            endcase
        end
    end

    // The prefix only moves on an accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= PFX_NONE;
        end else if (accept) begin
            prefix_reg <= prefix_next;
        end
    end

endmodule

/* rtl/tcce_queue.sv */
module tcce_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  tcce_pkg::cmd_t in_cmd,
    output logic           out_valid,
    input  logic           out_pop,
    output tcce_pkg::cmd_t out_cmd
);

    localparam int DEPTH = tcce_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcce_pkg::cmd_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/tcce_back.sv */
`include "text_console_char_engine_assert.svh"

module tcce_back #(
    parameter int COLS     = tcce_pkg::COLS_DEF,
    parameter int ROWS     = tcce_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [3:0]             cfg_data,
    input  logic                   q_valid,
    output logic                   q_pop,
    input  tcce_pkg::cmd_t         q_cmd,
    output tcce_pkg::back_status_t status,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tcce_pkg::out_item_t    m_item
);

    localparam int CELLS   = COLS * ROWS;
    localparam int AW      = $clog2(CELLS);
    localparam int PW      = $clog2(CELLS + 1);
    localparam int CW      = $clog2(COLS);
    localparam int TW      = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int SCR_TPH = (CELLS - COLS) % TAB_STOP;

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_WALK   = 9'b000000100,
        ST_DEL    = 9'b000001000,
        ST_DELEND = 9'b000010000,
        ST_SCR    = 9'b000100000,
        ST_SBLK   = 9'b001000000,
        ST_RDW    = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [TW-1:0]       tph_reg, tph_next;
    logic [PW-1:0]       wa_reg, wa_next;
    logic                nl_reg, nl_next;
    logic [7:0]          rchar_reg, rchar_next;
    logic [3:0]          rfg_reg, rfg_next;
    logic [3:0]          rbg_reg, rbg_next;
    logic [3:0]          fg_reg, bg_reg;
    logic                m_valid_reg, m_valid_next;
    tcce_pkg::out_item_t m_item_reg, m_item_next;

    logic [15:0]         mem [CELLS];
    logic [15:0]         mem_rdata_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [15:0]         mem_wdata;

    logic [15:0]         blank_cell;
    logic [PW-1:0]       pos_inc;
    logic [CW-1:0]       col_inc;
    logic [TW-1:0]       tph_inc;
    logic                scroll_go;

    assign blank_cell      = {bg_reg, fg_reg, tcce_pkg::CH_SPACE};
    assign status.clearing = state_reg == ST_CLEAR;
    assign cfg_ready       = 1'b1;
    assign m_valid         = m_valid_reg;
    assign m_item          = m_item_reg;

    // Cursor one cell further on, with column and tab phase wrapping.
    assign pos_inc = pos_reg + 1'b1;
    assign col_inc = (col_reg == CW'(COLS - 1)) ? '0 : col_reg + 1'b1;
    assign tph_inc = (tph_reg == TW'(TAB_STOP - 1)) ? '0 : tph_reg + 1'b1;

    // Command sequencer.
    always_comb begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        col_next     = col_reg;
        tph_next     = tph_reg;
        wa_next      = wa_reg;
        nl_next      = nl_reg;
        rchar_next   = rchar_reg;
        rfg_next     = rfg_reg;
        rbg_next     = rbg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = pos_reg[AW-1:0];
        mem_wdata    = blank_cell;
        mem_re       = 1'b0;
        mem_raddr    = AW'(q_cmd.idx);
        scroll_go    = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = wa_reg[AW-1:0];
                mem_wdata = tcce_pkg::RESET_CELL;
                if (wa_reg == PW'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    wa_next = wa_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    rchar_next = '0;
                    rfg_next   = '0;
                    rbg_next   = '0;
                    state_next = ST_OUT;
                    unique case (q_cmd.kind)
                        tcce_pkg::CMD_READ: begin
                            if ({21'd0, q_cmd.idx} < 32'(CELLS)) begin
                                mem_re     = 1'b1;
                                state_next = ST_RDW;
                            end
                        end
                        tcce_pkg::CMD_CHAR: begin
                            mem_we    = 1'b1;
                            mem_wdata = {bg_reg, fg_reg, q_cmd.chr};
                            pos_next  = pos_inc;
                            col_next  = col_inc;
                            tph_next  = tph_inc;
                            scroll_go = pos_inc == PW'(CELLS);
                        end
                        tcce_pkg::CMD_NEWLINE, tcce_pkg::CMD_TAB: begin
                            nl_next    = q_cmd.kind == tcce_pkg::CMD_NEWLINE;
                            state_next = ST_WALK;
                        end
                        tcce_pkg::CMD_BACK: begin
                            mem_we = 1'b1;
                            if (pos_reg != '0) begin
                                pos_next  = pos_reg - 1'b1;
                                mem_waddr = AW'(pos_reg - 1'b1);
                                col_next  = (col_reg == '0) ? CW'(COLS - 1) : col_reg - 1'b1;
                                tph_next  = (tph_reg == '0) ? TW'(TAB_STOP - 1)
                                                            : tph_reg - 1'b1;
                            end
                        end
                        tcce_pkg::CMD_DELETE: begin
                            if (pos_reg == PW'(CELLS - 1)) begin
                                mem_we = 1'b1;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(pos_inc);
                                wa_next    = pos_reg;
                                state_next = ST_DEL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Blank one cell a cycle up to the row end or the next tab stop.
            ST_WALK: begin
                mem_we   = 1'b1;
                pos_next = pos_inc;
                col_next = col_inc;
                tph_next = tph_inc;
                if (pos_inc == PW'(CELLS)) begin
                    scroll_go = 1'b1;
                end else if (nl_reg ? (col_inc == '0) : (tph_inc == '0)) begin
                    state_next = ST_OUT;
                end
            end
            // Shift cells left: the cell read last cycle lands one place lower.
            ST_DEL: begin
                mem_we    = 1'b1;
                mem_waddr = wa_reg[AW-1:0];
                mem_wdata = mem_rdata_reg;
                if (wa_reg < PW'(CELLS - 2)) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(wa_reg + PW'(2));
                    wa_next   = wa_reg + 1'b1;
                end else begin
                    state_next = ST_DELEND;
                end
            end
            ST_DELEND: begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(CELLS - 1);
                state_next = ST_OUT;
            end
            // Move every row up by one, one cell a cycle.
            ST_SCR: begin
                mem_we    = 1'b1;
                mem_waddr = wa_reg[AW-1:0];
                mem_wdata = mem_rdata_reg;
                if (wa_reg < PW'(CELLS - COLS - 1)) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(wa_reg + PW'(COLS + 1));
                    wa_next   = wa_reg + 1'b1;
                end else begin
                    wa_next    = PW'(CELLS - COLS);
                    state_next = ST_SBLK;
                end
            end
            // Blank the bottom row, then park the cursor at its start.
            ST_SBLK: begin
                mem_we    = 1'b1;
                mem_waddr = wa_reg[AW-1:0];
                if (wa_reg == PW'(CELLS - 1)) begin
                    pos_next   = PW'(CELLS - COLS);
                    col_next   = '0;
                    tph_next   = TW'(SCR_TPH);
                    state_next = ST_OUT;
                end else begin
                    wa_next = wa_reg + 1'b1;
                end
            end
            ST_RDW: begin
                rchar_next = mem_rdata_reg[7:0];
                rfg_next   = mem_rdata_reg[11:8];
                rbg_next   = mem_rdata_reg[15:12];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_item_next.cursor    = 11'(pos_reg);
                    m_item_next.cell_char = rchar_reg;
                    m_item_next.cell_fg   = rfg_reg;
                    m_item_next.cell_bg   = rbg_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Start a scroll: fetch the first cell of the second row.
        if (scroll_go) begin
            mem_re     = 1'b1;
            mem_raddr  = AW'(COLS);
            wa_next    = '0;
            state_next = ST_SCR;
        end
    end

    // Screen memory with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        rchar_reg  <= rchar_next;
        rfg_reg    <= rfg_next;
        rbg_reg    <= rbg_next;
        m_item_reg <= m_item_next;
        nl_reg     <= nl_next;
    end

    // Control registers and colors.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            pos_reg     <= '0;
            col_reg     <= '0;
            tph_reg     <= '0;
            wa_reg      <= '0;
            m_valid_reg <= 1'b0;
            fg_reg      <= 4'hF;
            bg_reg      <= 4'h0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            col_reg     <= col_next;
            tph_reg     <= tph_next;
            wa_reg      <= wa_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    tcce_pkg::CFG_FG: fg_reg <= cfg_data;
                    tcce_pkg::CFG_BG: bg_reg <= cfg_data;
                endcase
            end
        end
    end

    // Cursor and its column and tab phase stay on the screen between commands.
    `TCCE_ASSERT_IMP(a_idle_pos, state_reg == ST_IDLE, pos_reg < PW'(CELLS))
    `TCCE_ASSERT_IMP(a_idle_phase, state_reg == ST_IDLE,
        col_reg <= CW'(COLS - 1) && tph_reg <= TW'(TAB_STOP - 1))
    `TCCE_ASSERT_IMP(a_walk_pos, state_reg == ST_WALK, pos_reg < PW'(CELLS))
    `TCCE_ASSERT_NXT(a_out_load, state_reg == ST_OUT && (!m_valid_reg || m_ready),
        m_valid_reg && state_reg == ST_IDLE)

endmodule

/* rtl/text_console_char_engine.sv */
// Newline and tab blank the cells up to the stop, and delete shifts every cell after the
// cursor one place lower; a scroll moves all rows but the top one up and blanks the last.
// The screen memory moves one cell a cycle, which sets how long these take.
// Throughput: one item at a time in the back; the command queue holds two more.
// Reset: synchronous, active low; a clearing pass over the whole screen follows,
// during which no item is accepted (configuration writes are).
module text_console_char_engine #(
    parameter int COLS     = tcce_pkg::COLS_DEF,
    parameter int ROWS     = tcce_pkg::ROWS_DEF,
    parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcce_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output tcce_pkg::out_item_t m_item
);

    tcce_pkg::cmd_t         f_cmd, q_cmd;
    logic                   f_valid, f_ready;
    logic                   q_valid, q_pop;
    tcce_pkg::back_status_t status;

    // Front: UTF-8 prefix handling and classification.
    tcce_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .status  (status),
        .q_ready (f_ready),
        .q_valid (f_valid),
        .q_cmd   (f_cmd)
    );

    // Command queue.
    tcce_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_cmd    (f_cmd),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_cmd   (q_cmd)
    );

    // Back: screen memory and cursor.
    tcce_back #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_cmd     (q_cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

/* sim/text_console_char_engine_tb.sv */
`timescale 1ns / 100ps

module text_console_char_engine_tb;

    localparam int COLS  = tcce_pkg::COLS_DEF;
    localparam int ROWS  = tcce_pkg::ROWS_DEF;
    localparam int TABW  = tcce_pkg::TAB_STOP_DEF;
    localparam int CELLS = COLS * ROWS;

    // Code page 437 codes after a 0xC2 lead byte (second byte 0xA1 to 0xBF).
    localparam logic [7:0] CP_AFTER_C2 [31] = '{
        173, 155, 156, 234, 157, 179, 21, 234, 234, 166, 234, 170, 174, 234, 234, 248,
        241, 253, 234, 39, 230, 20, 249, 44, 49, 167, 175, 172, 171, 234, 168
    };

    // Code page 437 codes after a 0xC3 lead byte (second byte 0x80 to 0xBF).
    localparam logic [7:0] CP_AFTER_C3 [64] = '{
        65, 65, 65, 65, 142, 143, 146, 128, 69, 144, 69, 69, 73, 73, 73, 73,
        68, 165, 79, 79, 79, 79, 153, 120, 79, 85, 85, 85, 154, 89, 48, 225,
        133, 160, 131, 97, 132, 134, 145, 135, 138, 130, 136, 137, 141, 161, 140, 139,
        235, 164, 149, 162, 147, 111, 148, 246, 237, 151, 163, 150, 129, 121, 0, 152
    };

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_index = tcce_pkg::CFG_FG;
    logic [3:0] cfg_data = 4'd0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    tcce_pkg::in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    tcce_pkg::out_item_t m_item;

    // Shadow copy of the console state.
    logic [15:0] shadow_screen [CELLS];
    int unsigned shadow_cursor;
    logic [1:0]  shadow_prefix;
    logic [3:0]  shadow_fg;
    logic [3:0]  shadow_bg;

    tcce_pkg::out_item_t pending_results [$];
    int          error_count = 0;
    bit          stall_enable = 1'b1;

    typedef struct {
        tcce_pkg::in_item_t  beat;
        bit                  fixed;
        tcce_pkg::out_item_t want;
    } stim_row_t;

    stim_row_t stim_rows [$];

    text_console_char_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    always #2 aclk = ~aclk;

    // Hard limit on run time.
    initial begin
        #20000000;
        $display("text_console_char_engine: mismatch");
        $finish;
    end

    function automatic logic [15:0] blank_cell();
        return {shadow_bg, shadow_fg, tcce_pkg::CH_SPACE};
    endfunction

    function automatic void blank_span(int unsigned from, int unsigned upto);
        for (int unsigned k = from; k < upto && k < CELLS; k++) begin
            shadow_screen[k] = blank_cell();
        end
    endfunction

    // Apply one character code to the shadow screen and cursor.
    function automatic void apply_char(logic [7:0] c);
        int unsigned pos;
        int unsigned stop;
        pos = shadow_cursor;
        if (c == tcce_pkg::CH_NUL) begin
            return;
        end
        if (c == tcce_pkg::CH_NL) begin
            stop = COLS * (pos / COLS + 1);
            blank_span(pos, stop);
            pos = stop;
        end else if (c == tcce_pkg::CH_TAB) begin
            stop = TABW * (pos / TABW + 1);
            if (stop > CELLS) begin
                stop = CELLS;
            end
            blank_span(pos, stop);
            pos = stop;
        end else if (c == tcce_pkg::CH_BS) begin
            if (pos > 0) begin
                pos--;
            end
            shadow_screen[pos] = blank_cell();
        end else if (c == tcce_pkg::CH_DEL) begin
            for (int unsigned k = pos; k + 1 < CELLS; k++) begin
                shadow_screen[k] = shadow_screen[k + 1];
            end
            shadow_screen[CELLS - 1] = blank_cell();
        end else begin
            shadow_screen[pos] = {shadow_bg, shadow_fg, c};
            pos++;
        end
        // Scroll up one row once the cursor runs off the screen.
        if (pos >= CELLS) begin
            for (int unsigned k = 0; k < CELLS - COLS; k++) begin
                shadow_screen[k] = shadow_screen[k + COLS];
            end
            blank_span(CELLS - COLS, CELLS);
            pos = CELLS - COLS;
        end
        shadow_cursor = pos;
    endfunction

    // Work out the result of one beat and update the shadow state.
    function automatic tcce_pkg::out_item_t console_result(tcce_pkg::in_item_t it);
        tcce_pkg::out_item_t r;
        logic [7:0] b;
        r = '0;
        b = it.byte_in;
        if (it.operation == tcce_pkg::OP_READ) begin
            if (it.cell_index < CELLS) begin
                r.cell_char = shadow_screen[it.cell_index][7:0];
                r.cell_fg   = shadow_screen[it.cell_index][11:8];
                r.cell_bg   = shadow_screen[it.cell_index][15:12];
            end
        end else if (shadow_prefix == 2'd1) begin
            shadow_prefix = 2'd0;
            apply_char((b >= tcce_pkg::C2_LOW && b <= tcce_pkg::C2_HIGH)
                       ? CP_AFTER_C2[b - tcce_pkg::C2_LOW] : tcce_pkg::CH_QMARK);
        end else if (shadow_prefix == 2'd2) begin
            shadow_prefix = 2'd0;
            apply_char((b >= 8'h80 && b <= 8'hBF) ? CP_AFTER_C3[b - 8'h80]
                                                  : tcce_pkg::CH_QMARK);
        end else if (b == tcce_pkg::UTF_C2) begin
            shadow_prefix = 2'd1;
        end else if (b == tcce_pkg::UTF_C3) begin
            shadow_prefix = 2'd2;
        end else begin
            apply_char(b);
        end
        r.cursor = shadow_cursor[10:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Send one beat; the expectation is queued when the beat is accepted.
    task automatic send_beat(input tcce_pkg::in_item_t it, input bit fixed,
                             input tcce_pkg::out_item_t want);
        tcce_pkg::out_item_t r;
        while (stall_enable && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = console_result(it);
        pending_results.push_back(fixed ? want : r);
    endtask

    task automatic feed_byte(input logic [7:0] b);
        send_beat('{operation: tcce_pkg::OP_FEED, byte_in: b, cell_index: 11'($urandom)},
                  1'b0, '0);
    endtask

    // Drain all results, then write both colour registers.
    task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= tcce_pkg::CFG_FG;
        cfg_data  <= fg;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow_fg = fg;
        cfg_index <= tcce_pkg::CFG_BG;
        cfg_data  <= bg;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow_bg = bg;
        cfg_valid <= 1'b0;
    endtask

    task automatic add_row(input logic op, input logic [7:0] b, input logic [10:0] idx,
                           input bit fixed, input tcce_pkg::out_item_t want);
        stim_row_t row;
        row.beat  = '{operation: op, byte_in: b, cell_index: idx};
        row.fixed = fixed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // One random beat, mostly well-formed text with some reads and noise.
    task automatic random_beat();
        int unsigned pick;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 15) begin
            send_beat('{operation: tcce_pkg::OP_READ, byte_in: 8'($urandom),
                        cell_index: ($urandom_range(9) < 8) ? 11'($urandom_range(CELLS - 1))
                                                           : 11'($urandom_range(2047))},
                      1'b0, '0);
        end else if (pick < 60) begin
            feed_byte(8'($urandom_range(8'h7E, 8'h20)));
        end else if (pick < 67) begin
            feed_byte(tcce_pkg::CH_NL);
        end else if (pick < 72) begin
            feed_byte(tcce_pkg::CH_TAB);
        end else if (pick < 76) begin
            feed_byte(tcce_pkg::CH_BS);
        end else if (pick < 78) begin
            feed_byte(tcce_pkg::CH_DEL);
        end else if (pick < 80) begin
            feed_byte(tcce_pkg::CH_NUL);
        end else if (pick < 92) begin
            // Two-byte UTF-8 sequence, usually with a second byte from 0x80 to 0xBF.
            feed_byte(($urandom_range(1) == 0) ? tcce_pkg::UTF_C2 : tcce_pkg::UTF_C3);
            b = ($urandom_range(9) < 8) ? 8'($urandom_range(8'hBF, 8'h80)) : 8'($urandom);
            feed_byte(b);
        end else begin
            feed_byte(8'($urandom));
        end
    endtask

    // Result side: random stalls and comparison against the oldest expectation.
    always @(posedge aclk) begin
        tcce_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat, cursor", m_item.cursor, -1);
            end else begin
                want = pending_results.pop_front();
                if (m_item.cursor !== want.cursor)
                    report_mismatch("cursor", m_item.cursor, want.cursor);
                if (m_item.cell_char !== want.cell_char)
                    report_mismatch("cell_char", m_item.cell_char, want.cell_char);
                if (m_item.cell_fg !== want.cell_fg)
                    report_mismatch("cell_fg", m_item.cell_fg, want.cell_fg);
                if (m_item.cell_bg !== want.cell_bg)
                    report_mismatch("cell_bg", m_item.cell_bg, want.cell_bg);
            end
        end
        m_ready <= !(stall_enable && $urandom_range(99) < 19);
    end

    // Stimulus sequence.
    initial begin
        for (int k = 0; k < CELLS; k++) begin
            shadow_screen[k] = tcce_pkg::RESET_CELL;
        end
        shadow_cursor = 0;
        shadow_prefix = 2'd0;
        shadow_fg     = 4'hF;
        shadow_bg     = 4'h0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        set_colors(4'hF, 4'h0);

        // Directed rows: fixed expectations where obvious, the rest predicted.
        add_row(tcce_pkg::OP_READ, 8'h00, 11'd0, 1'b1,
                '{cursor: 0, cell_char: 8'h20, cell_fg: 15, cell_bg: 0});
        add_row(tcce_pkg::OP_READ, 8'hFF, 11'd1999, 1'b1,
                '{cursor: 0, cell_char: 8'h20, cell_fg: 15, cell_bg: 0});
        add_row(tcce_pkg::OP_READ, 8'h00, 11'd2000, 1'b1, '0);
        add_row(tcce_pkg::OP_READ, 8'hFF, 11'd2047, 1'b1, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::CH_BS, 11'd0, 1'b1, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::CH_NUL, 11'd2047, 1'b1, '0);
        add_row(tcce_pkg::OP_FEED, 8'h41, 11'd0, 1'b1,
                '{cursor: 1, cell_char: 0, cell_fg: 0, cell_bg: 0});
        add_row(tcce_pkg::OP_FEED, 8'hFF, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, 8'h80, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::CH_TAB, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::CH_BS, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::CH_NL, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::CH_DEL, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C2, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_READ, 8'h00, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::C2_LOW, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C2, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::C2_HIGH, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C2, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C3, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C3, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, 8'h80, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C3, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, 8'hBE, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C3, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C2, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::UTF_C2, 11'd0, 1'b0, '0);
        add_row(tcce_pkg::OP_FEED, tcce_pkg::CH_NUL, 11'd0, 1'b0, '0);
        foreach (stim_rows[i]) begin
            send_beat(stim_rows[i].beat, stim_rows[i].fixed, stim_rows[i].want);
        end

        // Walk to the bottom row and tab past the last cell.
        set_colors(4'h0, 4'h0);
        repeat (ROWS) feed_byte(tcce_pkg::CH_NL);
        repeat (COLS - 3) feed_byte(8'h78);
        feed_byte(tcce_pkg::CH_TAB);
        for (int k = 0; k < 8; k++) begin
            send_beat('{operation: tcce_pkg::OP_READ, byte_in: 8'h00,
                        cell_index: 11'(CELLS - COLS - 4 + k)}, 1'b0, '0);
        end

        // Random phases under different colours; one phase runs without stalls.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: set_colors(4'hF, 4'hF);
                1: set_colors(4'h0, 4'hF);
                2: set_colors(4'hA, 4'h5);
                default: set_colors(4'($urandom), 4'($urandom));
            endcase
            stall_enable = (phase != 2);
            repeat (55) random_beat();
        end
        stall_enable = 1'b1;
        s_valid <= 1'b0;

        // Drain and finish.
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("text_console_char_engine: match");
        end else begin
            $display("text_console_char_engine: mismatch");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_front.sv
rtl/tcce_queue.sv
rtl/tcce_back.sv
rtl/text_console_char_engine.sv
sim/text_console_char_engine_tb.sv
